FILE: hw/rtl/esd_pkg.sv
// shared types and constants for the escape sequence decoder
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned MAX_OUT     = 4;

   localparam logic [7:0] BSLASH     = 8'h5C;
   localparam logic [7:0] ESC_CODE   = 8'h1B;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] HEX_OFFSET = 8'd10;

   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [2:0]              count;
      logic                    fin;
   } bundle_type;

endpackage

`default_nettype wire

FILE: hw/rtl/escape_sequence_decoder.sv
// Backslash escape decoder for a byte stream.
// Input side is a queue: a transaction is taken when req_push is high and
// req_full is low; req_data_byte carries one character, req_final_byte
// marks the last character of a string. Output side is a queue too: the
// oldest decoded byte sits on rsp_out_byte while rsp_empty is low and is
// taken when rsp_pop is high. rsp_run_last flags the last byte produced by
// one input transaction, rsp_string_done the last byte of the string.
// One input byte is accepted per cycle while req_full is low. Each input
// produces zero to four output bytes; these leave one per cycle on
// rsp_pop, so the output rate sets the sustained input rate when escapes
// expand. Results are registered in a bundle queue of QUEUE_DEPTH
// entries, which decouples the two sides: if the receiver stalls the
// input keeps flowing until the queue fills, then req_full rises.
// Synchronous reset empties the queue and returns the decoder to plain text.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder #(
   parameter int unsigned QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_push,
   output logic       req_full,
   input  wire  [7:0] req_data_byte,
   input  wire        req_final_byte,
   output logic       rsp_empty,
   input  wire        rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);
   import esd_pkg::*;

   bundle_type wr_bundle, head_bundle;
   logic       wr_valid, head_pop, accept;

   assign accept = req_push && !req_full;

   esd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .final_byte   (req_final_byte),
      .bundle       (wr_bundle),
      .bundle_valid (wr_valid)
   );

   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_valid),
      .wr_data (wr_bundle),
      .rd_en   (head_pop),
      .rd_data (head_bundle),
      .full    (req_full),
      .empty   (rsp_empty)
   );

   esd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_bundle),
      .head_empty  (rsp_empty),
      .head_pop    (head_pop),
      .pop         (rsp_pop),
      .out_byte    (rsp_out_byte),
      .run_last    (rsp_run_last),
      .string_done (rsp_string_done)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/esd_front.sv
// front end: classifies each input byte and builds its bundle of output bytes
`timescale 1ns / 1ps
`default_nettype none

module esd_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                accept,
   input  wire  [7:0]         data_byte,
   input  wire                final_byte,
   output esd_pkg::bundle_type bundle,
   output logic               bundle_valid
);
   import esd_pkg::*;

   typedef enum logic [4:0] {
      PH_PLAIN = 5'b00001,
      PH_ESC   = 5'b00010,
      PH_HEX1  = 5'b00100,
      PH_HEX2  = 5'b01000,
      PH_OCT   = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] oval_ff, oval_in;
   logic [1:0] seen_ff, seen_in;
   bundle_type b;

   function automatic bundle_type put(bundle_type cur, logic [7:0] v);
      bundle_type r;
      r = cur;
      if (cur.count < 3'(MAX_OUT)) begin
         r.bytes[cur.count[1:0]] = v;
         r.count = cur.count + 3'd1;
      end
      return r;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] t;
      if (c >= "0" && c <= "9") begin
         t = c - "0";
      end else begin
         t = (c | CASE_BIT) - "a" + HEX_OFFSET;
      end
      return t[3:0];
   endfunction

   function automatic logic is_oct(logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       tail_plain;
      logic [1:0] seen_inc;
      c          = data_byte;
      tail_plain = 1'b0;
      seen_inc   = seen_ff + 2'd1;
      phase_in   = phase_ff;
      held_in    = held_ff;
      oval_in    = oval_ff;
      seen_in    = seen_ff;
      b          = '0;
      b.fin      = final_byte;
      unique case (phase_ff)
         PH_ESC: begin
            phase_in = PH_PLAIN;
            unique case (c)
               BSLASH: b = put(b, BSLASH);
               "n":    b = put(b, 8'h0A);
               "t":    b = put(b, 8'h09);
               "a":    b = put(b, 8'h07);
               "b":    b = put(b, 8'h08);
               "f":    b = put(b, 8'h0C);
               "r":    b = put(b, 8'h0D);
               "v":    b = put(b, 8'h0B);
               "e":    b = put(b, ESC_CODE);
               "x":    phase_in = PH_HEX1;
               default: begin
                  if (is_oct(c)) begin
                     phase_in = PH_OCT;
                     oval_in  = c - "0";
                     seen_in  = 2'd1;
                  end else begin
                     b          = put(b, BSLASH);
                     tail_plain = 1'b1;
                  end
               end
            endcase
         end
         PH_HEX1: begin
            if (is_hex(c)) begin
               held_in  = c;
               phase_in = PH_HEX2;
            end else begin
               phase_in   = PH_PLAIN;
               b          = put(b, BSLASH);
               b          = put(b, "x");
               tail_plain = 1'b1;
            end
         end
         PH_HEX2: begin
            phase_in = PH_PLAIN;
            if (is_hex(c)) begin
               b = put(b, {hex_val(held_ff), hex_val(c)});
            end else begin
               b          = put(b, BSLASH);
               b          = put(b, "x");
               b          = put(b, held_ff);
               tail_plain = 1'b1;
            end
            held_in = '0;
         end
         PH_OCT: begin
            if (is_oct(c)) begin
               oval_in = {oval_ff[4:0], 3'b000} + (c - "0");
               seen_in = seen_inc;
               if (seen_inc == 2'd3 || seen_inc == 2'd0) begin
                  b        = put(b, oval_in);
                  phase_in = PH_PLAIN;
                  oval_in  = '0;
                  seen_in  = '0;
               end
            end else begin
               b          = put(b, oval_ff);
               phase_in   = PH_PLAIN;
               oval_in    = '0;
               seen_in    = '0;
               tail_plain = 1'b1;
            end
         end
         default: begin
            phase_in   = PH_PLAIN;
            tail_plain = 1'b1;
         end
      endcase

      if (tail_plain) begin
         if (c == BSLASH) begin
            phase_in = PH_ESC;
         end else begin
            b = put(b, c);
         end
      end

      if (final_byte) begin
         unique case (phase_in)
            PH_ESC: b = put(b, BSLASH);
            PH_HEX1: begin
               b = put(b, BSLASH);
               b = put(b, "x");
            end
            PH_HEX2: begin
               b = put(b, BSLASH);
               b = put(b, "x");
               b = put(b, held_in);
            end
            PH_OCT:  b = put(b, oval_in);
            default: ;
         endcase
         phase_in = PH_PLAIN;
         held_in  = '0;
         oval_in  = '0;
         seen_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         held_ff  <= '0;
         oval_ff  <= '0;
         seen_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         oval_ff  <= oval_in;
         seen_ff  <= seen_in;
      end
   end

   assign bundle       = b;
   assign bundle_valid = accept && (b.count != 3'd0);

endmodule

`default_nettype wire

FILE: hw/rtl/esd_queue.sv
// short queue of output bundles between front and back
`timescale 1ns / 1ps
`default_nettype none

module esd_queue #(
   parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      wr_en,
   input  wire esd_pkg::bundle_type wr_data,
   input  wire                      rd_en,
   output esd_pkg::bundle_type      rd_data,
   output logic                     full,
   output logic                     empty
);
   import esd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   bundle_type     entries_ff [DEPTH];
   logic [PW-1:0]  wptr_ff, wptr_in;
   logic [PW-1:0]  rptr_ff, rptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_wr, do_rd;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = entries_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/esd_back.sv
// back end: serializes each bundle into single-byte transactions
`timescale 1ns / 1ps
`default_nettype none

module esd_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire esd_pkg::bundle_type head,
   input  wire                      head_empty,
   output logic                     head_pop,
   input  wire                      pop,
   output logic [7:0]               out_byte,
   output logic                     run_last,
   output logic                     string_done
);
   import esd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign take        = pop && !head_empty;
   assign out_byte    = head.bytes[idx_ff];
   assign run_last    = ({1'b0, idx_ff} + 3'd1) == head.count;
   assign string_done = run_last && head.fin;
   assign head_pop    = take && run_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = run_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire
